### hdl/assert_macros.svh
// Assertion macros shared by the vector unpack expander RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### hdl/vue_pkg.sv
// Types and codes shared by the vector unpack expander modules.
package vue_pkg;

    typedef enum logic [1:0] {
        SZ_32    = 2'd0,
        SZ_16    = 2'd1,
        SZ_8     = 2'd2,
        SZ_COLOR = 2'd3
    } t_elem_size;

    typedef enum logic [1:0] {
        CNT_S  = 2'd0,
        CNT_V2 = 2'd1,
        CNT_V3 = 2'd2,
        CNT_V4 = 2'd3
    } t_vec_count;

    typedef logic [3:0][31:0] t_words;

    typedef struct packed {
        logic [3:0]  operation;
        logic        zero_extend;
        logic [31:0] src_word0;
        logic [31:0] src_word1;
        logic [31:0] src_word2;
        logic [31:0] src_word3;
    } t_in_req;

    typedef struct packed {
        logic [31:0] lane_x;
        logic [31:0] lane_y;
        logic [31:0] lane_z;
        logic [31:0] lane_w;
        logic        bad_format;
    } t_out_req;

endpackage

### hdl/vue_in_if.sv
// Source request channel of the vector unpack expander.
interface vue_in_if;
    import vue_pkg::*;

    logic    valid;
    logic    ready;
    t_in_req req;

    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

### hdl/vue_out_if.sv
// Result request channel of the vector unpack expander.
interface vue_out_if;
    import vue_pkg::*;

    logic     valid;
    logic     ready;
    t_out_req req;

    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

### hdl/vue_lane.sv
// One unpack lane: extracts and extends the source element for its lane index.
module vue_lane (
    input  logic [1:0]          i_lane_idx,
    input  vue_pkg::t_elem_size i_size,
    input  logic                i_zero_extend,
    input  vue_pkg::t_words     i_words,
    output logic [31:0]         o_elem
);
    import vue_pkg::*;

    logic [31:0] half_src;
    logic [15:0] half_val;
    logic [7:0]  byte_val;
    logic [15:0] color;
    logic [7:0]  chan_val;

    always_comb begin
        half_src = i_words[{1'b0, i_lane_idx[1]}];
        half_val = i_lane_idx[0] ? half_src[31:16] : half_src[15:0];
        byte_val = i_words[0][{i_lane_idx, 3'b000} +: 8];
        color    = i_words[0][15:0];
        case (i_lane_idx)
            2'd0:    chan_val = {color[4:0], 3'b000};
            2'd1:    chan_val = {color[9:5], 3'b000};
            2'd2:    chan_val = {color[14:10], 3'b000};
            default: chan_val = {color[15], 7'b0000000};
        endcase
        case (i_size)
            SZ_32:   o_elem = i_words[i_lane_idx];
            SZ_16:   o_elem = {{16{half_val[15] & ~i_zero_extend}}, half_val};
            SZ_8:    o_elem = {{24{byte_val[7] & ~i_zero_extend}}, byte_val};
            default: o_elem = {24'd0, chan_val};
        endcase
    end
endmodule

### hdl/vue_merge.sv
// Merge stage: places lane elements by vector count or flags bad format.
module vue_merge (
    input  logic [3:0]        i_operation,
    input  logic [3:0][31:0]  i_elems,
    output vue_pkg::t_out_req o_res
);
    import vue_pkg::*;

    t_elem_size size;
    t_vec_count count;

    always_comb begin
        size  = t_elem_size'(i_operation[1:0]);
        count = t_vec_count'(i_operation[3:2]);
        o_res = '0;
        if (size == SZ_COLOR && count != CNT_V4) begin
            o_res.bad_format = 1'b1;
        end else begin
            case (count)
                CNT_S: begin
                    o_res.lane_x = i_elems[0];
                    o_res.lane_y = i_elems[0];
                    o_res.lane_z = i_elems[0];
                    o_res.lane_w = i_elems[0];
                end
                CNT_V2: begin
                    o_res.lane_x = i_elems[0];
                    o_res.lane_y = i_elems[1];
                    o_res.lane_z = i_elems[0];
                    o_res.lane_w = (size == SZ_32) ? 32'd0 : i_elems[1];
                end
                CNT_V3: begin
                    o_res.lane_x = i_elems[0];
                    o_res.lane_y = i_elems[1];
                    o_res.lane_z = i_elems[2];
                end
                default: begin
                    o_res.lane_x = i_elems[0];
                    o_res.lane_y = i_elems[1];
                    o_res.lane_z = i_elems[2];
                    o_res.lane_w = i_elems[3];
                end
            endcase
        end
    end
endmodule

### hdl/vue_skid.sv
// Output register with a skid stage so that a new request is taken during a stall.
module vue_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vue_pkg::t_out_req i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output vue_pkg::t_out_req o_res
);
    import vue_pkg::*;

    `include "assert_macros.svh"

    logic     r_out_valid, n_out_valid;
    logic     r_skid_valid, n_skid_valid;
    t_out_req r_out, n_out;
    t_out_req r_skid, n_skid;
    logic     in_fire;
    logic     out_free;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        in_fire      = i_valid && !r_skid_valid;
        out_free     = !r_out_valid || i_ready;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            n_out_valid  = r_skid_valid || in_fire;
            n_out        = r_skid_valid ? r_skid : i_res;
            n_skid_valid = 1'b0;
        end else if (in_fire) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    `ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n, in_fire && r_out_valid && !i_ready,
        r_skid_valid && r_out_valid)
    `ASSERT_NXT(a_drain_moves_skid, i_clk, i_rst_n, r_skid_valid && i_ready,
        r_out_valid && !r_skid_valid && r_out == $past(r_skid))
endmodule

### hdl/vector_unpack_expander.sv
// Top level of the vector unpack expander: four unpack lanes, merge and output buffer.
//
// Usage: each source request on i_src carries a 4-bit unpack format, a
// zero-extend flag and 128 source bits in four little-endian words. The
// block answers every source request with exactly one result request on
// o_res holding four 32-bit lanes and a bad-format flag.
// A request accepted at a clock edge is taken into the output register, or into the
// skid register while the receiver stalls. Throughput is one request per cycle while
// o_res.ready stays high; the four lanes and the merge stage are combinational, and
// the only storage is the output register and its one-entry skid register.
// When the receiver stalls, the result waits in the output register and one
// further source request is still taken into the skid register; i_src.ready
// falls only while the skid register is full.
// Reset empties both registers; the block holds no other state.
module vector_unpack_expander (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vue_in_if.sink    i_src,
    vue_out_if.source o_res
);
    import vue_pkg::*;

    `include "assert_macros.svh"

    t_words           words;
    t_elem_size       size;
    logic [3:0][31:0] elems;
    t_out_req         merged;

    assign words = {i_src.req.src_word3, i_src.req.src_word2,
                    i_src.req.src_word1, i_src.req.src_word0};
    assign size  = t_elem_size'(i_src.req.operation[1:0]);

    for (genvar g = 0; g < 4; g++) begin : g_lane
        vue_lane u_lane (
            .i_lane_idx    (2'(g)),
            .i_size        (size),
            .i_zero_extend (i_src.req.zero_extend),
            .i_words       (words),
            .o_elem        (elems[g])
        );
    end

    vue_merge u_merge (
        .i_operation (i_src.req.operation),
        .i_elems     (elems),
        .o_res       (merged)
    );

    vue_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_src.valid),
        .o_ready (i_src.ready),
        .i_res   (merged),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (o_res.req)
    );

    `ASSERT_IMP(a_bad_lanes_zero, i_clk, i_rst_n, merged.bad_format,
        merged.lane_x == 32'd0 && merged.lane_y == 32'd0 &&
        merged.lane_z == 32'd0 && merged.lane_w == 32'd0)
    `ASSERT_IMP(a_bad_only_invalid, i_clk, i_rst_n, merged.bad_format,
        size == SZ_COLOR && i_src.req.operation[3:2] != CNT_V4)
    `ASSERT_NXT(a_accept_gives_result, i_clk, i_rst_n, i_src.valid && i_src.ready,
        o_res.valid)
endmodule

### verif/vector_unpack_expander_tb.sv
// Self-checking testbench of the vector unpack expander: directed table, random requests, stalls.
module vector_unpack_expander_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vue_pkg::*;

    localparam int unsigned RANDOM_REQUESTS = 1000;
    localparam int unsigned LONG_HOLD       = 64;
    localparam int unsigned IDLE_LIMIT      = 1000;
    localparam int unsigned PRINT_LIMIT     = 40;
    localparam int unsigned HOLD_AT         = 300;
    localparam int unsigned DRAIN_AT        = 600;

    typedef struct packed {
        t_in_req  req;
        logic     typed;
        t_out_req res;
    } t_unpack_row;

    localparam t_out_req NO_LANES = '0;
    localparam t_out_req BAD_LANES = '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1};

    logic i_clk = 1'b0;
    logic i_rst_n;

    vue_in_if  src_ch ();
    vue_out_if res_ch ();

    vector_unpack_expander dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_ch),
        .o_res   (res_ch)
    );

    t_out_req    lanes_due [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_done     = 0;
    bit          no_idle_src    = 1'b0;
    bit          no_idle_sink   = 1'b0;

    t_unpack_row unpack_rows [23] = '{
        '{'{{CNT_S, SZ_32}, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0}},
        '{'{{CNT_S, SZ_32}, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, NO_LANES},
        '{'{{CNT_S, SZ_16}, 1'b0, 32'h00008000, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 1'b0}},
        '{'{{CNT_S, SZ_16}, 1'b1, 32'h00008000, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'h00008000, 32'h00008000, 32'h00008000, 32'h00008000, 1'b0}},
        '{'{{CNT_S, SZ_8}, 1'b0, 32'h00000080, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'hFFFFFF80, 32'hFFFFFF80, 32'hFFFFFF80, 32'hFFFFFF80, 1'b0}},
        '{'{{CNT_S, SZ_8}, 1'b1, 32'h000000FF, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'h000000FF, 32'h000000FF, 32'h000000FF, 32'h000000FF, 1'b0}},
        '{'{{CNT_S, SZ_COLOR}, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b1, BAD_LANES},
        '{'{{CNT_V2, SZ_32}, 1'b0, 32'h11111111, 32'h22222222, 32'h33333333, 32'h44444444},
          1'b1, '{32'h11111111, 32'h22222222, 32'h11111111, 32'h0, 1'b0}},
        '{'{{CNT_V2, SZ_16}, 1'b0, 32'h7FFF8000, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'hFFFF8000, 32'h00007FFF, 32'hFFFF8000, 32'h00007FFF, 1'b0}},
        '{'{{CNT_V2, SZ_8}, 1'b1, 32'hC3A58180, 32'h12345678, 32'h9ABCDEF0, 32'h0},
          1'b0, NO_LANES},
        '{'{{CNT_V2, SZ_COLOR}, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b1, BAD_LANES},
        '{'{{CNT_V3, SZ_32}, 1'b0, 32'h80000000, 32'h7FFFFFFF, 32'hA5A5A5A5, 32'hFFFFFFFF},
          1'b0, NO_LANES},
        '{'{{CNT_V3, SZ_16}, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b0, NO_LANES},
        '{'{{CNT_V3, SZ_8}, 1'b0, 32'h80FF7F80, 32'h0, 32'h0, 32'h0}, 1'b0, NO_LANES},
        '{'{{CNT_V3, SZ_COLOR}, 1'b0, 32'hDEADBEEF, 32'hCAFEF00D, 32'h5A5A5A5A, 32'h01234567},
          1'b1, BAD_LANES},
        '{'{{CNT_V4, SZ_32}, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0}},
        '{'{{CNT_V4, SZ_16}, 1'b0, 32'h80007FFF, 32'hFFFF0001, 32'h0, 32'h0}, 1'b0, NO_LANES},
        '{'{{CNT_V4, SZ_8}, 1'b0, 32'h807F00FF, 32'h0, 32'h0, 32'h0}, 1'b0, NO_LANES},
        '{'{{CNT_V4, SZ_8}, 1'b1, 32'h807F00FF, 32'h0, 32'h0, 32'h0}, 1'b0, NO_LANES},
        '{'{{CNT_V4, SZ_COLOR}, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b1, '{32'h000000F8, 32'h000000F8, 32'h000000F8, 32'h00000080, 1'b0}},
        '{'{{CNT_V4, SZ_COLOR}, 1'b1, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b1, NO_LANES},
        '{'{{CNT_V4, SZ_COLOR}, 1'b0, 32'h00005555, 32'h0, 32'h0, 32'h0}, 1'b0, NO_LANES},
        '{'{{CNT_V4, SZ_16}, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b0, NO_LANES}
    };

    always #6 i_clk = ~i_clk;

    function automatic t_out_req unpack_lanes(input t_in_req r);
        t_out_req         lanes;
        t_elem_size       size;
        t_vec_count       count;
        t_words           w;
        logic [3:0][31:0] e;
        lanes = '0;
        e     = '0;
        size  = t_elem_size'(r.operation[1:0]);
        count = t_vec_count'(r.operation[3:2]);
        w     = {r.src_word3, r.src_word2, r.src_word1, r.src_word0};
        if (size == SZ_COLOR && count != CNT_V4) begin
            lanes.bad_format = 1'b1;
        end else if (size == SZ_COLOR) begin
            lanes.lane_x = {24'd0, w[0][4:0], 3'd0};
            lanes.lane_y = {24'd0, w[0][9:5], 3'd0};
            lanes.lane_z = {24'd0, w[0][14:10], 3'd0};
            lanes.lane_w = {24'd0, w[0][15], 7'd0};
        end else begin
            for (int i = 0; i < 4; i++) begin
                case (size)
                    SZ_32: e[i] = w[i];
                    SZ_16: e[i] = {{16{~r.zero_extend & w[i >> 1][16 * (i & 1) + 15]}},
                                   w[i >> 1][16 * (i & 1) +: 16]};
                    default: e[i] = {{24{~r.zero_extend & w[0][8 * i + 7]}},
                                     w[0][8 * i +: 8]};
                endcase
            end
            case (count)
                CNT_S: begin
                    lanes.lane_x = e[0];
                    lanes.lane_y = e[0];
                    lanes.lane_z = e[0];
                    lanes.lane_w = e[0];
                end
                CNT_V2: begin
                    lanes.lane_x = e[0];
                    lanes.lane_y = e[1];
                    lanes.lane_z = e[0];
                    lanes.lane_w = (size == SZ_32) ? 32'd0 : e[1];
                end
                CNT_V3: begin
                    lanes.lane_x = e[0];
                    lanes.lane_y = e[1];
                    lanes.lane_z = e[2];
                end
                default: begin
                    lanes.lane_x = e[0];
                    lanes.lane_y = e[1];
                    lanes.lane_z = e[2];
                    lanes.lane_w = e[3];
                end
            endcase
        end
        return lanes;
    endfunction

    function automatic logic [31:0] pick_word();
        logic [31:0] word;
        word = $urandom;
        case ($urandom_range(0, 7))
            0: word = 32'h0;
            1: word = 32'hFFFFFFFF;
            2: word = word | 32'h80808080;
            default: ;
        endcase
        return word;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t ns: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_lane(input string field, input logic [31:0] got,
                              input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, wanted %h", field, got, want));
        end
    endtask

    task automatic send_request(input t_in_req req, input logic typed, input t_out_req res);
        int unsigned gap;
        gap = no_idle_src ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            src_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_ch.valid <= 1'b1;
        src_ch.req   <= req;
        @(posedge i_clk);
        while (!src_ch.ready) @(posedge i_clk);
        lanes_due.push_back(typed ? res : unpack_lanes(req));
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_req due;
        if (i_rst_n) begin
            if ((src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (lanes_due.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    due = lanes_due.pop_front();
                    check_lane("lane_x", res_ch.req.lane_x, due.lane_x);
                    check_lane("lane_y", res_ch.req.lane_y, due.lane_y);
                    check_lane("lane_z", res_ch.req.lane_z, due.lane_z);
                    check_lane("lane_w", res_ch.req.lane_w, due.lane_w);
                    check_lane("bad_format", 32'(res_ch.req.bad_format), 32'(due.bad_format));
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int unsigned gap;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (holds_done != holds_asked) begin
                holds_done++;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                gap = no_idle_sink ? 0 : $urandom_range(0, 7);
                if (gap != 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
                while (!res_ch.valid) @(posedge i_clk);
            end
        end
    end

    initial begin : request_source
        t_in_req req;
        i_rst_n      <= 1'b0;
        src_ch.valid <= 1'b0;
        src_ch.req   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (unpack_rows[i]) begin
            send_request(unpack_rows[i].req, unpack_rows[i].typed, unpack_rows[i].res);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0) begin
                no_idle_src  = ($urandom_range(0, 3) == 0);
                no_idle_sink = ($urandom_range(0, 3) == 0);
            end
            if (n == HOLD_AT) begin
                no_idle_src = 1'b1;
                holds_asked++;
            end
            if (n == DRAIN_AT) begin
                src_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (lanes_due.size() != 0) @(posedge i_clk);
            end
            req.operation   = 4'($urandom_range(0, 15));
            req.zero_extend = 1'($urandom_range(0, 1));
            req.src_word0   = pick_word();
            req.src_word1   = pick_word();
            req.src_word2   = pick_word();
            req.src_word3   = pick_word();
            send_request(req, 1'b0, NO_LANES);
        end

        src_ch.valid <= 1'b0;
        while (lanes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### vector_unpack_expander.f
+incdir+hdl
hdl/vue_pkg.sv
hdl/vue_in_if.sv
hdl/vue_out_if.sv
hdl/vue_lane.sv
hdl/vue_merge.sv
hdl/vue_skid.sv
hdl/vector_unpack_expander.sv
verif/vector_unpack_expander_tb.sv
